// ===== rtl/core/assert_macros.svh =====
// Assertion helpers; clk_i and rst_ni must be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/pwm_pkg.sv =====
package pwm_pkg;

  localparam int POS_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 24;
  localparam int SPAN_W     = 25;
  localparam int SUM_W      = VAL_W + CNT_W;
  localparam int QUO_W      = 32;
  localparam int FIFO_DEPTH = 4;

  localparam logic [SPAN_W-1:0] SPAN_MIN   = 25'd2;
  localparam logic [SPAN_W-1:0] SPAN_MAX   = 25'd16777216;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 25'd1024;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  typedef enum logic [1:0] {
    ST_MEAN  = 2'd0,
    ST_ORDER = 2'd1,
    ST_ZERO  = 2'd2
  } status_e;

  // Classified item; kind ST_MEAN marks a sample that enters a window.
  typedef struct packed {
    status_e            kind;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   value;
    logic               eos;
  } item_t;

  typedef struct packed {
    logic   push;
    item_t  item;
  } push_t;

  typedef struct packed {
    logic              start;
    logic [SPAN_W-1:0] hi;
    logic [QUO_W-1:0]  lo;
    logic [SPAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUO_W-1:0]  quotient;
    logic [SPAN_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/core/position_window_mean_top.sv =====
// Binned mean over position-tagged Q16.16 samples: windows of window_span
// positions starting at position 1; a sample beyond the open window closes
// it and reports its truncated mean if it holds samples, bad positions
// report an error and are dropped, and tlast on a sample flushes the open
// window and restarts. The front accepts one sample per cycle into a
// four-entry queue while it is not full; the back takes one sample at a
// time. Closing a window with samples runs the shared 32-step divider for
// the mean and then for the span advance, closing an empty window runs it
// for the span advance only, and a flush with samples runs it for the mean.
// The result register lets the next sample enter while a result waits.
module position_window_mean_top
  import pwm_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [SPAN_W-1:0]            cfg_data_i,     // window_span
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [POS_W+VAL_W-1:0]       s_axis_tdata,   // position, sample_value
  input  logic                         s_axis_tlast,   // end_of_stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // window_start, window_mean, sample_count
  output logic [POS_W+VAL_W+CNT_W-1:0] m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,   // status
  output logic                         m_axis_tlast    // last_of_run
);

  logic [SPAN_W-1:0] span_q;
  logic [SPAN_W-1:0] span_eff;
  logic              full;
  logic              empty;
  logic              pop;
  push_t             push;
  item_t             head;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= SPAN_RESET;
    end else if (cfg_valid_i) begin
      span_q <= cfg_data_i;
    end
  end

  // Clamp the span into its legal range.
  assign span_eff = (span_q < SPAN_MIN) ? SPAN_MIN :
                    (span_q > SPAN_MAX) ? SPAN_MAX : span_q;

  pwm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .full_i     (full),
    .push_o     (push)
  );

  pwm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  pwm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pwm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .span_i     (span_eff),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

// ===== rtl/core/pwm_div.sv =====
// Restoring divider, one quotient bit per cycle. The high part of the
// dividend must be below the divisor so the quotient fits QUO_W bits.
module pwm_div
  import pwm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(QUO_W);

  logic [SPAN_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [SPAN_W-1:0] dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (req_i.start) begin
      rem_d  = req_i.hi;
      quo_d  = req_i.lo;
      dvs_d  = req_i.divisor;
      step_d = STEP_W'(QUO_W - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[SPAN_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = trial[SPAN_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== rtl/core/pwm_front.sv =====
// Accept samples and sort out bad positions from the last good position
// alone; it waits only on a full queue, not on window arithmetic.
module pwm_front
  import pwm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [POS_W+VAL_W-1:0] s_tdata_i,
  input  logic                   s_tlast_i,
  input  logic                   full_i,
  output push_t                  push_o
);

  logic [POS_W-1:0] prev_q, prev_d;
  logic [POS_W-1:0] pos;
  logic             accept;
  status_e          kind;

  assign pos        = s_tdata_i[POS_W-1:0];
  assign s_tready_o = !full_i;
  assign accept     = s_tvalid_i && s_tready_o;

  // Order check wins over the zero check.
  always_comb begin
    if (pos < prev_q) begin
      kind = ST_ORDER;
    end else if (pos == '0) begin
      kind = ST_ZERO;
    end else begin
      kind = ST_MEAN;
    end
  end

  always_comb begin
    prev_d = prev_q;
    if (accept) begin
      if (s_tlast_i) begin
        prev_d = '0;
      end else if (kind == ST_MEAN) begin
        prev_d = pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

  assign push_o.push       = accept;
  assign push_o.item.kind  = kind;
  assign push_o.item.pos   = pos;
  assign push_o.item.value = s_tdata_i[POS_W+VAL_W-1:POS_W];
  assign push_o.item.eos   = s_tlast_i;

endmodule

// ===== rtl/core/pwm_fifo.sv =====
`include "assert_macros.svh"

module pwm_fifo
  import pwm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output item_t head_o
);

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  item_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FILL_W'(FIFO_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i.push) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push_i.push && !pop_i) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop_i && !push_i.push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  `ASSERT_CHK(a_fill_in_range, fill_q <= FILL_W'(FIFO_DEPTH))
  `ASSERT_CHK(a_pop_not_empty, pop_i |-> !empty_o)
  `ASSERT_CHK(a_push_not_full, push_i.push |-> !full_o)

endmodule

// ===== rtl/core/pwm_back.sv =====
`include "assert_macros.svh"

// Window engine: accumulate samples, close and flush windows, and drive
// the result register.
module pwm_back
  import pwm_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  item_t                          head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  input  logic [SPAN_W-1:0]              span_i,
  output div_req_t                       div_req_o,
  input  div_rsp_t                       div_rsp_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [POS_W+VAL_W+CNT_W-1:0]   m_tdata_o,
  output logic [1:0]                     m_tuser_o,
  output logic                           m_tlast_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_MDIV  = 6'b000100,
    S_SDIV  = 6'b001000,
    S_FLUSH = 6'b010000,
    S_FDIV  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  item_t             item_q, item_d;
  logic [POS_W-1:0]  start_q, start_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [POS_W-1:0]  out_start_q, out_start_d;
  logic [VAL_W-1:0]  out_mean_q, out_mean_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic              out_last_q, out_last_d;

  logic              out_free;
  logic [POS_W:0]    window_end;
  logic              closes;
  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [VAL_W-1:0]  mean;
  logic [SUM_W-1:0]  val_ext;
  logic [POS_W-1:0]  grid_offset;
  logic [POS_W-1:0]  new_start;
  div_req_t          mean_req;
  div_req_t          span_req;

  assign out_free    = !out_valid_q || m_tready_i;
  assign window_end  = {1'b0, start_q} + (POS_W + 1)'(span_i);
  assign closes      = ({1'b0, item_q.pos} > window_end);
  assign neg         = sum_q[SUM_W-1];
  assign mag         = neg ? (~sum_q + SUM_W'(1)) : sum_q;
  assign mean        = neg ? (~div_rsp_i.quotient + VAL_W'(1)) : div_rsp_i.quotient;
  assign val_ext     = {{(SUM_W-VAL_W){item_q.value[VAL_W-1]}}, item_q.value};
  assign grid_offset = item_q.pos - start_q - POS_W'(1);
  // Last start below the position on the span grid.
  assign new_start   = item_q.pos - POS_W'(1) - POS_W'(div_rsp_i.remainder);

  // |sum| <= count * 2^31, so the high part of the magnitude stays below
  // the count and the quotient fits 32 bits.
  always_comb begin
    mean_req.start   = 1'b1;
    mean_req.hi      = SPAN_W'(mag[SUM_W-1:QUO_W]);
    mean_req.lo      = mag[QUO_W-1:0];
    mean_req.divisor = SPAN_W'(cnt_q);
    span_req.start   = 1'b1;
    span_req.hi      = '0;
    span_req.lo      = grid_offset;
    span_req.divisor = span_i;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    start_d      = start_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    pop_o        = 1'b0;
    div_req_o    = span_req;
    div_req_o.start = 1'b0;
    out_valid_d  = out_valid_q && !m_tready_i;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    out_mean_d   = out_mean_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          item_d  = head_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (item_q.kind != ST_MEAN) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = item_q.kind;
            out_start_d  = start_q;
            out_mean_d   = '0;
            out_count_d  = '0;
            out_last_d   = !(item_q.eos && cnt_q != '0);
            state_d      = item_q.eos ? S_FLUSH : S_IDLE;
          end
        end else if (closes) begin
          if (cnt_q != '0) begin
            div_req_o = mean_req;
            state_d   = S_MDIV;
          end else begin
            div_req_o = span_req;
            state_d   = S_SDIV;
          end
        end else begin
          // Drop samples once the count is saturated.
          if (cnt_q != CNT_MAX) begin
            sum_d = sum_q + val_ext;
            cnt_d = cnt_q + CNT_W'(1);
          end
          state_d = item_q.eos ? S_FLUSH : S_IDLE;
        end
      end
      S_MDIV: begin
        if (div_rsp_i.done && out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_MEAN;
          out_start_d  = start_q;
          out_mean_d   = mean;
          out_count_d  = cnt_q;
          out_last_d   = !item_q.eos;
          div_req_o    = span_req;
          state_d      = S_SDIV;
        end
      end
      S_SDIV: begin
        if (div_rsp_i.done) begin
          start_d = new_start;
          sum_d   = val_ext;
          cnt_d   = CNT_W'(1);
          state_d = item_q.eos ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (cnt_q != '0) begin
          div_req_o = mean_req;
          state_d   = S_FDIV;
        end else begin
          start_d = POS_W'(1);
          sum_d   = '0;
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_FDIV: begin
        if (div_rsp_i.done && out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_MEAN;
          out_start_d  = start_q;
          out_mean_d   = mean;
          out_count_d  = cnt_q;
          out_last_d   = 1'b1;
          start_d      = POS_W'(1);
          sum_d        = '0;
          cnt_d        = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= POS_W'(1);
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
    out_mean_q   <= out_mean_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_count_q, out_mean_q, out_start_q};
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;

  `ASSERT_CHK(a_div_start_idle, div_req_o.start |-> !div_rsp_i.busy)
  `ASSERT_NEXT(a_pop_to_eval, pop_o, state_q == S_EVAL)
  `ASSERT_CHK(a_mean_has_count, (out_valid_q && out_status_q == ST_MEAN) |-> (out_count_q != '0))
  `ASSERT_CHK(a_err_is_empty, (out_valid_q && out_status_q != ST_MEAN) |-> (out_count_q == '0 && out_mean_q == '0))

endmodule
